// File: hw/rtl/pidsc_pkg.sv
// shared types, constants and rounding function for the pid steering controller
`timescale 1ns / 1ps

package pidsc_pkg;

  localparam int ERR_W   = 16;
  localparam int DIFF_W  = 17;
  localparam int GAIN_W  = 24;
  localparam int INTEG_W = 32;
  localparam int SQ_W    = 32;
  localparam int SQSUM_W = 48;
  localparam int CNT_W   = 32;
  localparam int STEER_W = 16;
  localparam int SUM_W   = 58;
  localparam int IDX_W   = 2;
  localparam int OUT_W   = STEER_W + SQSUM_W + CNT_W;

  localparam logic OP_PROCESS = 1'b0;
  localparam logic OP_CLEAR   = 1'b1;

  localparam logic [IDX_W-1:0] REG_GAIN_PROP  = 2'd0;
  localparam logic [IDX_W-1:0] REG_GAIN_INTEG = 2'd1;
  localparam logic [IDX_W-1:0] REG_GAIN_DERIV = 2'd2;

  localparam logic signed [STEER_W-1:0] STEER_ONE = 16'sd16384;
  localparam logic signed [SUM_W-1:0]   SUM_LIM   = 58'sd268435456;
  localparam logic signed [SUM_W-1:0]   SUM_HALF  = 58'sd8192;

  typedef struct packed {
    logic                       clr;
    logic signed [ERR_W-1:0]    e;
    logic signed [DIFF_W-1:0]   d;
    logic signed [INTEG_W-1:0]  integ;
    logic [SQSUM_W-1:0]         sq_total;
    logic [CNT_W-1:0]           count;
  } acc_t;

  typedef struct packed {
    logic                       clr;
    logic signed [SUM_W-1:0]    sum;
    logic [SQSUM_W-1:0]         sq_total;
    logic [CNT_W-1:0]           count;
  } law_t;

  // negate, clamp to +/-1.0 and round half up to q1.14
  function automatic logic signed [STEER_W-1:0] steer_round(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] n;
    logic signed [SUM_W-1:0] r;
    n = -s;
    r = n + SUM_HALF;
    if (n >= SUM_LIM) begin
      return STEER_ONE;
    end else if (n <= -SUM_LIM) begin
      return -STEER_ONE;
    end else begin
      return r[14 +: STEER_W];
    end
  endfunction

endpackage

// File: hw/rtl/pidsc_accum.sv
// error state update: previous error, saturating integral, squared sum and count
`timescale 1ns / 1ps

module pidsc_accum (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  load,
  input  logic                                  clr,
  input  logic signed [pidsc_pkg::ERR_W-1:0]    e,
  input  logic [pidsc_pkg::SQ_W-1:0]            sq,
  output pidsc_pkg::acc_t                       acc_r
);

  logic signed [pidsc_pkg::ERR_W-1:0]     prev_r;
  logic signed [pidsc_pkg::INTEG_W-1:0]   integ_r;
  logic [pidsc_pkg::SQSUM_W-1:0]          sqsum_r;
  logic [pidsc_pkg::CNT_W-1:0]            cnt_r;

  logic signed [pidsc_pkg::INTEG_W:0]     integ_ext;
  logic signed [pidsc_pkg::INTEG_W-1:0]   integ_nxt;
  logic [pidsc_pkg::SQSUM_W:0]            sqsum_ext;
  logic [pidsc_pkg::SQSUM_W-1:0]          sqsum_nxt;
  logic [pidsc_pkg::CNT_W-1:0]            cnt_nxt;
  logic signed [pidsc_pkg::DIFF_W-1:0]    d;
  pidsc_pkg::acc_t                        acc_nxt;

  always_comb begin
    integ_ext = integ_r + e;
    sqsum_ext = {1'b0, sqsum_r} + {{(pidsc_pkg::SQSUM_W + 1 - pidsc_pkg::SQ_W){1'b0}}, sq};
    d         = e - prev_r;
    if (integ_ext[pidsc_pkg::INTEG_W] != integ_ext[pidsc_pkg::INTEG_W-1]) begin
      integ_nxt = integ_ext[pidsc_pkg::INTEG_W] ? {1'b1, {(pidsc_pkg::INTEG_W-1){1'b0}}}
                                                : {1'b0, {(pidsc_pkg::INTEG_W-1){1'b1}}};
    end else begin
      integ_nxt = integ_ext[pidsc_pkg::INTEG_W-1:0];
    end
    sqsum_nxt = sqsum_ext[pidsc_pkg::SQSUM_W] ? {pidsc_pkg::SQSUM_W{1'b1}}
                                              : sqsum_ext[pidsc_pkg::SQSUM_W-1:0];
    cnt_nxt   = (&cnt_r) ? cnt_r : cnt_r + 1'b1;
    if (clr) begin
      integ_nxt = '0;
      sqsum_nxt = '0;
      cnt_nxt   = '0;
    end
    acc_nxt.clr      = clr;
    acc_nxt.e        = e;
    acc_nxt.d        = d;
    acc_nxt.integ    = integ_nxt;
    acc_nxt.sq_total = sqsum_nxt;
    acc_nxt.count    = cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      integ_r <= '0;
      sqsum_r <= '0;
      cnt_r   <= '0;
    end else if (load) begin
      prev_r  <= clr ? '0 : e;
      integ_r <= integ_nxt;
      sqsum_r <= sqsum_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      acc_r <= acc_nxt;
    end
  end

endmodule

// File: hw/rtl/pidsc_law.sv
// control law: three gain products, then their sum
`timescale 1ns / 1ps

module pidsc_law (
  input  logic                                  clk,
  input  logic                                  load_prod,
  input  logic                                  load_sum,
  input  pidsc_pkg::acc_t                       acc,
  input  logic signed [pidsc_pkg::GAIN_W-1:0]   gain_prop,
  input  logic signed [pidsc_pkg::GAIN_W-1:0]   gain_integ,
  input  logic signed [pidsc_pkg::GAIN_W-1:0]   gain_deriv,
  output pidsc_pkg::law_t                       law_r
);

  logic signed [pidsc_pkg::GAIN_W+pidsc_pkg::ERR_W-1:0]   p_prop_r;
  logic signed [pidsc_pkg::GAIN_W+pidsc_pkg::INTEG_W-1:0] p_integ_r;
  logic signed [pidsc_pkg::GAIN_W+pidsc_pkg::DIFF_W-1:0]  p_deriv_r;
  logic                                                    clr_r;
  logic [pidsc_pkg::SQSUM_W-1:0]                           sq_total_r;
  logic [pidsc_pkg::CNT_W-1:0]                             count_r;
  logic signed [pidsc_pkg::SUM_W-1:0]                      sum;

  always_ff @(posedge clk) begin
    if (load_prod) begin
      p_prop_r   <= gain_prop * acc.e;
      p_integ_r  <= gain_integ * acc.integ;
      p_deriv_r  <= gain_deriv * acc.d;
      clr_r      <= acc.clr;
      sq_total_r <= acc.sq_total;
      count_r    <= acc.count;
    end
  end

  assign sum = p_prop_r + p_integ_r + p_deriv_r;

  always_ff @(posedge clk) begin
    if (load_sum) begin
      law_r.clr      <= clr_r;
      law_r.sum      <= sum;
      law_r.sq_total <= sq_total_r;
      law_r.count    <= count_r;
    end
  end

endmodule

// File: hw/rtl/pid_steering_controller_core.sv
// top level of the pid steering controller: stream ports, gain registers and pipeline
`timescale 1ns / 1ps

// One error sample enters per cycle while the output is not stalled. After the transfer
// in, its result passes the input register, state update, gain products, product sum,
// then the clamped and rounded output register. The state update feeds back its own state,
// so samples stream back to back with no gaps. Each stage holds while the next is full,
// so a stalled output only stops input once every stage is occupied. Gains are written
// through the cfg port and take effect on the products stage; write them while idle.
// A clear item zeroes the error state and returns an all-zero result.

module pid_steering_controller_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [pidsc_pkg::ERR_W-1:0]         in_tdata,   // [15:0] error_sample
  input  logic                                in_tuser,   // [0] opcode
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [pidsc_pkg::OUT_W-1:0]         out_tdata,  // [15:0] steer,
                                                          // [63:16] squared_error_total,
                                                          // [95:64] sample_total
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pidsc_pkg::IDX_W-1:0]         cfg_index,
  input  logic [pidsc_pkg::GAIN_W-1:0]        cfg_data
);

  logic signed [pidsc_pkg::GAIN_W-1:0] gain_prop_r;
  logic signed [pidsc_pkg::GAIN_W-1:0] gain_integ_r;
  logic signed [pidsc_pkg::GAIN_W-1:0] gain_deriv_r;

  logic                                 v0_r, va_r, vb_r, vc_r, vo_r;
  logic                                 rdy0, rdya, rdyb, rdyc, rdyo;
  logic                                 clr0_r;
  logic signed [pidsc_pkg::ERR_W-1:0]   e0_r;
  logic [pidsc_pkg::SQ_W-1:0]           sq0_r;
  logic signed [pidsc_pkg::SQ_W-1:0]    in_sq;
  pidsc_pkg::acc_t                      acc;
  pidsc_pkg::law_t                      law;
  logic signed [pidsc_pkg::STEER_W-1:0] steer;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_prop_r  <= '0;
      gain_integ_r <= '0;
      gain_deriv_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        pidsc_pkg::REG_GAIN_PROP:  gain_prop_r  <= cfg_data;
        pidsc_pkg::REG_GAIN_INTEG: gain_integ_r <= cfg_data;
        pidsc_pkg::REG_GAIN_DERIV: gain_deriv_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage readiness, each stage can fill while the one after it holds
  assign rdyo      = !vo_r || out_tready;
  assign rdyc      = !vc_r || rdyo;
  assign rdyb      = !vb_r || rdyc;
  assign rdya      = !va_r || rdyb;
  assign rdy0      = !v0_r || rdya;
  assign in_tready = rdy0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (rdy0) v0_r <= in_tvalid;
      if (rdya) va_r <= v0_r;
      if (rdyb) vb_r <= va_r;
      if (rdyc) vc_r <= vb_r;
      if (rdyo) vo_r <= vc_r;
    end
  end

  assign in_sq = $signed(in_tdata) * $signed(in_tdata);

  always_ff @(posedge clk) begin
    if (rdy0 && in_tvalid) begin
      clr0_r <= (in_tuser == pidsc_pkg::OP_CLEAR);
      e0_r   <= in_tdata;
      sq0_r  <= in_sq;
    end
  end

  pidsc_accum u_accum (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (rdya && v0_r),
    .clr   (clr0_r),
    .e     (e0_r),
    .sq    (sq0_r),
    .acc_r (acc)
  );

  pidsc_law u_law (
    .clk        (clk),
    .load_prod  (rdyb && va_r),
    .load_sum   (rdyc && vb_r),
    .acc        (acc),
    .gain_prop  (gain_prop_r),
    .gain_integ (gain_integ_r),
    .gain_deriv (gain_deriv_r),
    .law_r      (law)
  );

  assign steer = law.clr ? '0 : pidsc_pkg::steer_round(law.sum);

  always_ff @(posedge clk) begin
    if (rdyo && vc_r) begin
      out_tdata <= {law.count, law.sq_total, steer};
    end
  end

  assign out_tvalid = vo_r;

endmodule

// File: bench/pid_steering_controller_checker.sv
// checker for the pid steering controller: tracks gains and state, predicts and compares results
`timescale 1ns / 1ps

module pid_steering_controller_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [pidsc_pkg::ERR_W-1:0]       in_tdata,
  input  logic                              in_tuser,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [pidsc_pkg::OUT_W-1:0]       out_tdata,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [pidsc_pkg::IDX_W-1:0]       cfg_index,
  input  logic [pidsc_pkg::GAIN_W-1:0]      cfg_data,
  output int                                mismatches,
  output int                                outstanding
);

  localparam int     SQ_LO      = pidsc_pkg::STEER_W;
  localparam int     CNT_LO     = pidsc_pkg::STEER_W + pidsc_pkg::SQSUM_W;
  localparam longint FULL_SCALE = longint'(1) <<< 28;
  localparam longint ROUND_HALF = longint'(1) <<< 13;
  localparam longint INTEG_HI   = (longint'(1) <<< 31) - 1;
  localparam longint INTEG_LO   = -(longint'(1) <<< 31);
  localparam logic [63:0] SQ_CEIL = {16'd0, {pidsc_pkg::SQSUM_W{1'b1}}};

  typedef struct packed {
    logic signed [pidsc_pkg::STEER_W-1:0] steer;
    logic [pidsc_pkg::SQSUM_W-1:0]        sq_total;
    logic [pidsc_pkg::CNT_W-1:0]          count;
  } steer_result_t;

  logic signed [pidsc_pkg::GAIN_W-1:0]  kp_gain;
  logic signed [pidsc_pkg::GAIN_W-1:0]  ki_gain;
  logic signed [pidsc_pkg::GAIN_W-1:0]  kd_gain;
  logic signed [pidsc_pkg::ERR_W-1:0]   last_err;
  logic signed [pidsc_pkg::INTEG_W-1:0] err_integral;
  logic [pidsc_pkg::SQSUM_W-1:0]        err_energy;
  logic [pidsc_pkg::CNT_W-1:0]          err_samples;

  steer_result_t pending_results[$];

  // update the error state with one sample, or clear it, and work out the drive value
  function automatic steer_result_t advance_controller(
    input logic                               op,
    input logic signed [pidsc_pkg::ERR_W-1:0] e
  );
    steer_result_t r;
    longint        diff;
    longint        integ_next;
    longint        law;
    longint        neg;
    longint        rnd;
    logic [63:0]   sq;
    r = '0;
    if (op == pidsc_pkg::OP_CLEAR) begin
      last_err     = '0;
      err_integral = '0;
      err_energy   = '0;
      err_samples  = '0;
      return r;
    end
    diff     = longint'(e) - longint'(last_err);
    last_err = e;

    integ_next = longint'(err_integral) + longint'(e);
    if (integ_next > INTEG_HI) integ_next = INTEG_HI;
    if (integ_next < INTEG_LO) integ_next = INTEG_LO;
    err_integral = integ_next[pidsc_pkg::INTEG_W-1:0];

    sq = 64'(longint'(e) * longint'(e));
    if ({16'd0, err_energy} + sq > SQ_CEIL) begin
      err_energy = '1;
    end else begin
      err_energy = err_energy + sq[pidsc_pkg::SQSUM_W-1:0];
    end

    if (err_samples != '1) err_samples = err_samples + 1'b1;

    law = longint'(kp_gain) * longint'(e) + longint'(ki_gain) * longint'(err_integral)
        + longint'(kd_gain) * diff;
    neg = -law;
    if (neg >= FULL_SCALE) begin
      r.steer = pidsc_pkg::STEER_ONE;
    end else if (neg <= -FULL_SCALE) begin
      r.steer = -pidsc_pkg::STEER_ONE;
    end else begin
      rnd     = (neg + ROUND_HALF) >>> 14;
      r.steer = rnd[pidsc_pkg::STEER_W-1:0];
    end
    r.sq_total = err_energy;
    r.count    = err_samples;
    return r;
  endfunction

  task automatic check_field(input string what, input longint want, input longint got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    steer_result_t got;
    steer_result_t want;
    if (!rst_n) begin
      kp_gain      = '0;
      ki_gain      = '0;
      kd_gain      = '0;
      last_err     = '0;
      err_integral = '0;
      err_energy   = '0;
      err_samples  = '0;
      pending_results.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.steer    = out_tdata[pidsc_pkg::STEER_W-1:0];
        got.sq_total = out_tdata[SQ_LO +: pidsc_pkg::SQSUM_W];
        got.count    = out_tdata[CNT_LO +: pidsc_pkg::CNT_W];
        if (pending_results.size() == 0) begin
          $display("%0t ns: result transfer with none expected, actual steer %0d sq %0d count %0d",
                   $time, got.steer, got.sq_total, got.count);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("steer", longint'(want.steer), longint'(got.steer));
          check_field("squared_error_total", longint'(want.sq_total), longint'(got.sq_total));
          check_field("sample_total", longint'(want.count), longint'(got.count));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pidsc_pkg::REG_GAIN_PROP:  kp_gain = $signed(cfg_data);
          pidsc_pkg::REG_GAIN_INTEG: ki_gain = $signed(cfg_data);
          pidsc_pkg::REG_GAIN_DERIV: kd_gain = $signed(cfg_data);
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        pending_results.push_back(advance_controller(in_tuser, $signed(in_tdata)));
      end
    end
    outstanding <= pending_results.size();
  end

endmodule

// File: bench/pid_steering_controller_core_tb.sv
// testbench top for the pid steering controller: clock, reset, stimulus, watchdog and verdict
`timescale 1ns / 1ps

module pid_steering_controller_core_tb;

  localparam logic [pidsc_pkg::IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RAND_PHASES    = 6;
  localparam int PHASE_ITEMS    = 70;

  logic                             clk = 1'b0;
  logic                             rst_n;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [pidsc_pkg::ERR_W-1:0]      in_tdata;
  logic                             in_tuser;
  logic                             out_tvalid;
  logic                             out_tready;
  logic [pidsc_pkg::OUT_W-1:0]      out_tdata;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [pidsc_pkg::IDX_W-1:0]      cfg_index;
  logic [pidsc_pkg::GAIN_W-1:0]     cfg_data;

  int mismatches;
  int outstanding;
  int quiet_cycles = 0;
  bit idle_en  = 1'b0;
  bit stall_en = 1'b0;
  bit hold_req = 1'b0;

  pid_steering_controller_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  pid_steering_controller_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("** pid_steering_controller_core: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random stall bursts and one long hold-off
  initial begin : result_side
    int  n;
    bit  hold_served;
    hold_served = 1'b0;
    out_tready  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_served) begin
        hold_served = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else if (stall_en && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 6);
        out_tready <= 1'b0;
        repeat (n - 1) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  function automatic logic [pidsc_pkg::GAIN_W-1:0] pick_gain();
    logic [31:0] raw;
    raw = $urandom;
    case ($urandom_range(0, 5))
      0:       return 24'h7F_FFFF;
      1:       return 24'h80_0000;
      2:       return '0;
      3:       return raw[pidsc_pkg::GAIN_W-1:0];
      default: begin
        raw = $urandom_range(0, 1 << 18) - (1 << 17);
        return raw[pidsc_pkg::GAIN_W-1:0];
      end
    endcase
  endfunction

  function automatic logic [pidsc_pkg::ERR_W-1:0] pick_error();
    logic [31:0] raw;
    raw = $urandom;
    case ($urandom_range(0, 4))
      0, 1:    ;
      2:       raw = $urandom_range(0, 1024) - 512;
      3:       raw = $urandom_range(0, 1) ? 32'h0000_7FFF : 32'hFFFF_8000;
      default: raw = $urandom_range(0, 16384) - 8192;
    endcase
    return raw[pidsc_pkg::ERR_W-1:0];
  endfunction

  task automatic send_item(input logic op, input logic [pidsc_pkg::ERR_W-1:0] e);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= e;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // stop offering and wait until every expected result has come back
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [pidsc_pkg::IDX_W-1:0] idx,
                           input logic [pidsc_pkg::GAIN_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic retune(input logic [pidsc_pkg::GAIN_W-1:0] kp,
                        input logic [pidsc_pkg::GAIN_W-1:0] ki,
                        input logic [pidsc_pkg::GAIN_W-1:0] kd);
    settle();
    write_reg(pidsc_pkg::REG_GAIN_PROP, kp);
    write_reg(pidsc_pkg::REG_GAIN_INTEG, ki);
    write_reg(pidsc_pkg::REG_GAIN_DERIV, kd);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = pidsc_pkg::OP_PROCESS;
    cfg_valid = 1'b0;
    cfg_index = pidsc_pkg::REG_GAIN_PROP;
    cfg_data  = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // mixed gains, field extremes, clears and an ignored write to the spare index
    retune(24'h01_0000, 24'h00_0100, 24'h00_8000);
    @(posedge clk);
    write_reg(REG_SPARE, 24'h7F_FFFF);
    cfg_valid <= 1'b0;
    send_item(pidsc_pkg::OP_PROCESS, 16'h0000);
    send_item(pidsc_pkg::OP_PROCESS, 16'h7FFF);
    send_item(pidsc_pkg::OP_PROCESS, 16'h8000);
    send_item(pidsc_pkg::OP_PROCESS, 16'h0001);
    send_item(pidsc_pkg::OP_PROCESS, 16'hFFFF);
    send_item(pidsc_pkg::OP_PROCESS, 16'h1000);
    send_item(pidsc_pkg::OP_PROCESS, 16'h0FFF);
    send_item(pidsc_pkg::OP_CLEAR,   16'h1234);
    send_item(pidsc_pkg::OP_PROCESS, 16'hF000);
    send_item(pidsc_pkg::OP_CLEAR,   16'h0000);
    send_item(pidsc_pkg::OP_CLEAR,   16'hFFFF);
    send_item(pidsc_pkg::OP_PROCESS, 16'h0800);

    // unit proportional gain: exact clamp boundary
    retune(24'h01_0000, 24'h00_0000, 24'h00_0000);
    send_item(pidsc_pkg::OP_PROCESS, 16'h1000);
    send_item(pidsc_pkg::OP_PROCESS, 16'hF000);
    send_item(pidsc_pkg::OP_PROCESS, 16'h0FFF);

    // smallest proportional gain: rounding of exact halves
    retune(24'h00_0001, 24'h00_0000, 24'h00_0000);
    send_item(pidsc_pkg::OP_PROCESS, 16'hE000);
    send_item(pidsc_pkg::OP_PROCESS, 16'h2000);
    send_item(pidsc_pkg::OP_PROCESS, 16'h6000);

    // extreme gains in both directions
    retune(24'h7F_FFFF, 24'h80_0000, 24'h7F_FFFF);
    send_item(pidsc_pkg::OP_PROCESS, 16'h7FFF);
    send_item(pidsc_pkg::OP_PROCESS, 16'h8000);
    send_item(pidsc_pkg::OP_PROCESS, 16'h0000);
    retune(24'h80_0000, 24'h7F_FFFF, 24'h80_0000);
    send_item(pidsc_pkg::OP_PROCESS, 16'h8000);
    send_item(pidsc_pkg::OP_PROCESS, 16'h7FFF);
    send_item(pidsc_pkg::OP_CLEAR,   16'h5A5A);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      idle_en  = (ph < RAND_PHASES - 1);
      stall_en = (ph < RAND_PHASES - 1);
      retune(pick_gain(), pick_gain(), pick_gain());
      if (ph == 2) hold_req = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 3 && k == PHASE_ITEMS / 2) settle();
        send_item(($urandom_range(0, 11) == 0) ? pidsc_pkg::OP_CLEAR : pidsc_pkg::OP_PROCESS,
                  pick_error());
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("** pid_steering_controller_core: PASSED **");
    end else begin
      $display("** pid_steering_controller_core: FAILED **");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/pidsc_pkg.sv
hw/rtl/pidsc_accum.sv
hw/rtl/pidsc_law.sv
hw/rtl/pid_steering_controller_core.sv
bench/pid_steering_controller_checker.sv
bench/pid_steering_controller_core_tb.sv
